/* hdl/dise_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Daily interval schedule evaluator package
// Shared widths, constants and word types for the evaluator and its step unit.
// ----------------------------------------------------------------------------
package dise_pkg;

  localparam int unsigned MINUTE_W     = 11;
  localparam int unsigned REG_COUNT    = 8;
  localparam int unsigned REG_W        = 2 * MINUTE_W;
  localparam int unsigned IDX_W        = $clog2(REG_COUNT);
  localparam int unsigned INTERVALS_DEF = 8;

  localparam logic [MINUTE_W-1:0] DAY_MINUTES = MINUTE_W'(1440);

  typedef logic [MINUTE_W-1:0] minute_t;

  typedef struct packed {
    minute_t now_minute;
  } in_word_t;

  typedef struct packed {
    logic    switch_on;
    minute_t next_on_minute;
    minute_t next_off_minute;
  } out_word_t;

  typedef struct packed {
    logic    on;
    minute_t next_on;
    minute_t off_best;
    minute_t min_start;
    minute_t min_end;
  } acc_t;

  localparam acc_t ACC_INIT = '{
    on:        1'b0,
    next_on:   DAY_MINUTES,
    off_best:  DAY_MINUTES,
    min_start: DAY_MINUTES,
    min_end:   DAY_MINUTES
  };

endpackage : dise_pkg
`default_nettype wire

/* hdl/dise_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload word per handshake between a source and a sink.
// ----------------------------------------------------------------------------
interface dise_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface : dise_stream_if
`default_nettype wire

/* hdl/dise_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Interval step unit
// Folds one interval register into the running schedule accumulator.
// ----------------------------------------------------------------------------
module dise_step (
  input  dise_pkg::minute_t            now_minute_i,
  input  logic [dise_pkg::REG_W-1:0]   interval_i,
  input  dise_pkg::acc_t               acc_i,
  output dise_pkg::acc_t               acc_o
);

  import dise_pkg::*;

  minute_t start_m;
  minute_t end_m;
  logic    is_plain;
  logic    is_wrap;

  assign start_m  = interval_i[MINUTE_W-1:0];
  assign end_m    = interval_i[REG_W-1:MINUTE_W];
  assign is_plain = start_m < end_m;
  assign is_wrap  = end_m < start_m;

  always_comb begin
    acc_o = acc_i;
    if (is_plain) begin
      if (now_minute_i >= start_m && now_minute_i < end_m) begin
        acc_o.on = 1'b1;
      end
      if (now_minute_i < start_m) begin
        if (acc_i.next_on > start_m) begin
          acc_o.next_on = start_m;
        end
        if (acc_i.off_best > end_m) begin
          acc_o.off_best = end_m;
        end
      end else if (now_minute_i < end_m && acc_i.off_best > end_m) begin
        acc_o.off_best = end_m;
      end
    end else if (is_wrap) begin
      if (now_minute_i >= start_m || now_minute_i < end_m) begin
        acc_o.on = 1'b1;
      end
      if (now_minute_i >= start_m && acc_i.off_best > end_m) begin
        acc_o.off_best = end_m;
      end else if (now_minute_i < end_m && acc_i.off_best > end_m) begin
        acc_o.off_best = end_m;
      end else if (now_minute_i < start_m && acc_i.next_on > start_m) begin
        acc_o.next_on = start_m;
      end
    end
    if (is_plain || is_wrap) begin
      if (start_m < acc_i.min_start) begin
        acc_o.min_start = start_m;
      end
      if (end_m < acc_i.min_end) begin
        acc_o.min_end = end_m;
      end
    end
  end

endmodule : dise_step
`default_nettype wire

/* hdl/daily_interval_schedule_evaluator_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Daily interval schedule evaluator
// Checks a minute of the day against the interval registers and reports the
// switch state and the next switch-on and switch-off minutes.
// ----------------------------------------------------------------------------
// Usage:
// The input stream takes one word holding the current minute of the day.
// The output stream returns one word per input: the switch state and the next
// switch-on and switch-off minutes. The interval registers are to be written
// through the plain write port only while no word is in flight; the block
// itself does not enforce this. A word is scanned one interval per cycle
// through a single step unit, and no new word is taken until its result has
// been written to the output register.
// Input ready is high only while the scanner is idle.
// A finished result sits in an output register; the next word is accepted
// while it waits, and the scan of that word holds before writing its result
// until the receiver has taken the previous one.
// Reset clears every interval register, which disables all intervals, and
// empties the output register.
// ----------------------------------------------------------------------------
module daily_interval_schedule_evaluator_core #(
  parameter int unsigned INTERVALS = dise_pkg::INTERVALS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dise_stream_if.sink                   in_i,
  dise_stream_if.source                 out_o,
  input  logic                          cfg_we_i,
  input  logic [dise_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [dise_pkg::REG_W-1:0]    cfg_data_i
);

  import dise_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(INTERVALS - 1);

  logic [REG_W-1:0] interval_q [REG_COUNT];

  state_e           state_q;
  logic [IDX_W-1:0] idx_q;
  minute_t          now_q;
  acc_t             acc_q;
  acc_t             acc_step;
  logic             out_valid_q;
  out_word_t        out_word_q;
  out_word_t        result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        interval_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      interval_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  dise_step u_step (
    .now_minute_i (now_q),
    .interval_i   (interval_q[idx_q]),
    .acc_i        (acc_q),
    .acc_o        (acc_step)
  );

  always_comb begin
    result.switch_on       = acc_q.on;
    result.next_on_minute  = (acc_q.next_on == DAY_MINUTES) ?
                             acc_q.min_start : acc_q.next_on;
    result.next_off_minute = (acc_q.off_best == DAY_MINUTES) ?
                             acc_q.min_end : acc_q.off_best;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      now_q       <= '0;
      acc_q       <= ACC_INIT;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      if (state_q == S_DONE && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            now_q   <= in_i.payload.now_minute;
            acc_q   <= ACC_INIT;
            idx_q   <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          acc_q <= acc_step;
          if (idx_q == LastIdx) begin
            idx_q   <= '0;
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_word_q <= result;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_word_q;

`ifndef ASSERT_OFF
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == S_SCAN && idx_q == '0)
    else $error("Accepted word did not start a scan at the first interval.");

  a_scan_ends_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN && idx_q == LastIdx |=> state_q == S_DONE)
    else $error("Scan did not finish after the last interval.");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("Result word appeared without a finished scan.");

  a_idx_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_SCAN |-> idx_q == '0)
    else $error("Interval index moved outside a scan.");
`endif

endmodule : daily_interval_schedule_evaluator_core
`default_nettype wire

/* verif/dise_schedule_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Schedule evaluator result checker
// Keeps its own copy of the interval registers from the write port, predicts
// the result word for every accepted minute word and compares each returned
// word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module dise_schedule_checker #(
  parameter int unsigned INTERVALS = dise_pkg::INTERVALS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       minute_valid_i,
  input  logic                       minute_ready_i,
  input  dise_pkg::in_word_t         minute_word_i,
  input  logic                       result_valid_i,
  input  logic                       result_ready_i,
  input  dise_pkg::out_word_t        result_word_i,
  input  logic                       cfg_we_i,
  input  logic [dise_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [dise_pkg::REG_W-1:0] cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  import dise_pkg::*;

  logic [REG_W-1:0] sched_copy [REG_COUNT];
  out_word_t        awaited_results [$];
  out_word_t        want;
  int               fails = 0;

  function automatic out_word_t predict_switching(input minute_t now);
    out_word_t res;
    minute_t   s;
    minute_t   e;
    minute_t   n_on;
    minute_t   n_off;
    minute_t   lo_s;
    minute_t   lo_e;
    logic      on;
    n_on  = DAY_MINUTES;
    n_off = DAY_MINUTES;
    lo_s  = DAY_MINUTES;
    lo_e  = DAY_MINUTES;
    on    = 1'b0;
    for (int k = 0; k < INTERVALS && k < REG_COUNT; k++) begin
      s = sched_copy[k][MINUTE_W-1:0];
      e = sched_copy[k][REG_W-1:MINUTE_W];
      if (s == e) continue;
      if (s < e) begin
        if (now >= s && now < e) on = 1'b1;
        if (now < s) begin
          if (n_on > s) n_on = s;
          if (n_off > e) n_off = e;
        end else if (now < e && n_off > e) begin
          n_off = e;
        end
      end else begin
        if (now >= s || now < e) on = 1'b1;
        if (now >= s && n_off > e) begin
          n_off = e;
        end else if (now < e && n_off > e) begin
          n_off = e;
        end else if (now < s && n_on > s) begin
          n_on = s;
        end
      end
      if (s < lo_s) lo_s = s;
      if (e < lo_e) lo_e = e;
    end
    if (n_on == DAY_MINUTES) n_on = lo_s;
    if (n_off == DAY_MINUTES) n_off = lo_e;
    res.switch_on       = on;
    res.next_on_minute  = n_on;
    res.next_off_minute = n_off;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (sched_copy[k]) sched_copy[k] = '0;
      awaited_results.delete();
    end else begin
      if (result_valid_i && result_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result word with no minute word outstanding");
          fails++;
        end else begin
          want = awaited_results.pop_front();
          if (result_word_i.switch_on !== want.switch_on) begin
            $error("switch_on expected %0d actual %0d",
                   want.switch_on, result_word_i.switch_on);
            fails++;
          end
          if (result_word_i.next_on_minute !== want.next_on_minute) begin
            $error("next_on_minute expected %0d actual %0d",
                   want.next_on_minute, result_word_i.next_on_minute);
            fails++;
          end
          if (result_word_i.next_off_minute !== want.next_off_minute) begin
            $error("next_off_minute expected %0d actual %0d",
                   want.next_off_minute, result_word_i.next_off_minute);
            fails++;
          end
        end
      end
      if (minute_valid_i && minute_ready_i) begin
        awaited_results.push_back(predict_switching(minute_word_i.now_minute));
      end
      if (cfg_we_i) begin
        sched_copy[cfg_idx_i] = cfg_data_i;
      end
    end
    fail_count_o <= fails;
    pending_o    <= awaited_results.size();
  end

endmodule : dise_schedule_checker

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Schedule evaluator testbench
// Drives minute words in random bursts against a receiver that stalls on its
// own pattern, rewrites all interval registers between phases, and leaves the
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
  import dise_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned SETTLE      = 12;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_WORDS = 105;
  localparam int unsigned DAY_LAST    = 1439;
  localparam int unsigned REG_MAX     = 2948511;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_COMB} rx_mode_e;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [REG_W-1:0] cfg_data;
  logic [REG_W-1:0] sched [REG_COUNT];
  int               fail_count;
  int               pending;
  rx_mode_e         rx_mode = RX_STEADY;
  bit               long_hold_req = 1'b0;
  int               hold_left = 0;
  int               rx_tick = 0;
  int               burst_left = 0;
  int               idle_cycles = 0;

  dise_stream_if #(.payload_t(in_word_t))  minute_ch ();
  dise_stream_if #(.payload_t(out_word_t)) result_ch ();

  daily_interval_schedule_evaluator_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (minute_ch),
    .out_o      (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  dise_schedule_checker checker_inst (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .minute_valid_i (minute_ch.valid),
    .minute_ready_i (minute_ch.ready),
    .minute_word_i  (minute_ch.payload),
    .result_valid_i (result_ch.valid),
    .result_ready_i (result_ch.ready),
    .result_word_i  (result_ch.payload),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    rx_tick++;
    if (long_hold_req) begin
      hold_left     = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: result_ch.ready <= 1'b1;
        RX_COIN:   result_ch.ready <= ($urandom_range(0, 2) != 0);
        default:   result_ch.ready <= ((rx_tick % 7) > 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (minute_ch.valid && minute_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [REG_W-1:0] pack_interval(input int s, input int e);
    return {minute_t'(e), minute_t'(s)};
  endfunction

  function automatic logic [REG_W-1:0] random_interval();
    int s;
    int e;
    case ($urandom_range(0, 9))
      0: begin
        s = $urandom_range(0, DAY_LAST);
        e = s;
      end
      1, 2, 3, 4: begin
        s = $urandom_range(0, DAY_LAST - 1);
        e = $urandom_range(s + 1, DAY_LAST);
      end
      5, 6, 7: begin
        s = $urandom_range(1, DAY_LAST);
        e = $urandom_range(0, s - 1);
      end
      8: return REG_W'($urandom_range(0, REG_MAX));
      default: begin
        s = 0;
        e = 0;
      end
    endcase
    return pack_interval(s, e);
  endfunction

  function automatic minute_t pick_minute();
    logic [REG_W-1:0] r;
    int               b;
    if ($urandom_range(0, 2) != 0) return minute_t'($urandom_range(0, DAY_LAST));
    r = sched[$urandom_range(0, REG_COUNT - 1)];
    b = $urandom_range(0, 1) ? int'(r[MINUTE_W-1:0]) : int'(r[REG_W-1:MINUTE_W]);
    b = b + int'($urandom_range(0, 2)) - 1;
    if (b < 0) b = 0;
    if (b > DAY_LAST) b = DAY_LAST;
    return minute_t'(b);
  endfunction

  task automatic send_minute(input minute_t m);
    int gap;
    minute_ch.valid   <= 1'b1;
    minute_ch.payload <= '{now_minute: m};
    do @(posedge clk); while (minute_ch.ready !== 1'b1);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 25) : $urandom_range(0, 4);
      if (gap > 0) begin
        minute_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    minute_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_schedule();
    for (int k = 0; k < REG_COUNT; k++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= IDX_W'(k);
      cfg_data <= sched[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    minute_t probes_off [$] = '{0, 720, 1439};
    minute_t probes_a   [$] = '{0, 29, 30, 59, 60, 119, 120, 599, 600, 899, 900,
                                1379, 1380, 1439};
    minute_t probes_b   [$] = '{0, 1, 1023, 1024, 1438, 1439};
    rst_n             <= 1'b0;
    minute_ch.valid   <= 1'b0;
    minute_ch.payload <= '0;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_data          <= '0;
    foreach (sched[k]) sched[k] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probes_off[k]) send_minute(probes_off[k]);
    settle();
    sched = '{pack_interval(60, 120), pack_interval(1380, 30), pack_interval(500, 500),
              pack_interval(600, 900), '0, '0, '0, '0};
    load_schedule();
    foreach (probes_a[k]) send_minute(probes_a[k]);
    settle();
    sched = '{pack_interval(0, 1439), pack_interval(1440, 1438), pack_interval(2047, 0),
              pack_interval(1439, 1439), '0, '0, '0, pack_interval(1439, 1)};
    load_schedule();
    foreach (probes_b[k]) send_minute(probes_b[k]);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      foreach (sched[k]) sched[k] = (phase == PHASES - 1) ? '0 : random_interval();
      load_schedule();
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      if (phase == 2) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) send_minute(pick_minute());
    end
    settle();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule : testbench
